FILE: design/dsp_mailbox_with_command_framing_macros.svh
// Assertion macros used by the mailbox datapath (dspmb_dp).
`ifndef DSP_MAILBOX_WITH_COMMAND_FRAMING_MACROS_SVH
`define DSP_MAILBOX_WITH_COMMAND_FRAMING_MACROS_SVH

`ifndef ASSERT_OFF

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: design/dspmb_pkg.sv
package dspmb_pkg;

   localparam int MAILBOX_DEPTH = 16;
   localparam int IDX_W = $clog2(MAILBOX_DEPTH);
   localparam int CNT_W = $clog2(MAILBOX_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam int WORD_W = 32;
   localparam int HALF_W = 16;
   localparam int ACT_W = 3;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [SUM_W-1:0] sum_type;

   localparam idx_type LAST_IDX = idx_type'(MAILBOX_DEPTH - 1);
   localparam cnt_type DEPTH_CNT = cnt_type'(MAILBOX_DEPTH);
   localparam sum_type DEPTH_SUM = sum_type'(MAILBOX_DEPTH);

   localparam logic [WORD_W-1:0] STATUS_FLAG = 32'h8000_0000;
   localparam logic [WORD_W-1:0] DEFAULT_FRAME_LEN = 32'd2;

   localparam logic [ACT_W-1:0] ACT_POST_FROM = 3'd0;
   localparam logic [ACT_W-1:0] ACT_CHECK_FROM = 3'd1;
   localparam logic [ACT_W-1:0] ACT_READ_FROM = 3'd2;
   localparam logic [ACT_W-1:0] ACT_CHECK_TO = 3'd3;
   localparam logic [ACT_W-1:0] ACT_SEND_TO = 3'd4;
   localparam logic [ACT_W-1:0] ACT_ASSERT_IRQ = 3'd5;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [WORD_W-1:0] mail_word;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic              finish_valid;
      logic [HALF_W-1:0] finish_id;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic post;
      logic pop;
      logic check;
      logic send;
      logic arm;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } status_type;

endpackage

FILE: design/dspmb_ram.sv
module dspmb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/dspmb_ctrl.sv
module dspmb_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [dspmb_pkg::ACT_W-1:0]     action,
   input  dspmb_pkg::status_type           status,
   output logic                            busy,
   output dspmb_pkg::cmd_type              cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [dspmb_pkg::ACT_W-1:0] act_ff, act_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.load  = start && (state_ff == ST_IDLE);
      cmd.exec  = (state_ff == ST_EXEC);
      cmd.post  = cmd.exec && (act_ff == dspmb_pkg::ACT_POST_FROM) && !status.full;
      cmd.check = cmd.exec && (act_ff == dspmb_pkg::ACT_CHECK_FROM) && !status.empty;
      cmd.pop   = cmd.exec && (act_ff == dspmb_pkg::ACT_READ_FROM) && !status.empty;
      cmd.send  = cmd.exec && (act_ff == dspmb_pkg::ACT_SEND_TO);
      cmd.arm   = cmd.exec && (act_ff == dspmb_pkg::ACT_ASSERT_IRQ);
      act_in    = cmd.load ? action : act_ff;
   end

   assign busy = (state_ff == ST_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      act_ff <= act_in;
   end

endmodule

FILE: design/dspmb_dp.sv
`include "dsp_mailbox_with_command_framing_macros.svh"

module dspmb_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  dspmb_pkg::cmd_type               cmd,
   input  logic [dspmb_pkg::WORD_W-1:0]     mail_word,
   output dspmb_pkg::status_type            status,
   output logic                             rsp_valid,
   output dspmb_pkg::rsp_type               rsp_data
);

   logic [dspmb_pkg::WORD_W-1:0] word_ff, word_in;
   dspmb_pkg::idx_type           head_ff, head_in;
   dspmb_pkg::cnt_type           count_ff, count_in;
   logic [dspmb_pkg::WORD_W-1:0] last_ff, last_in;
   logic [dspmb_pkg::WORD_W-1:0] len_ff, len_in;
   logic [dspmb_pkg::WORD_W-1:0] seen_ff, seen_in;
   logic [dspmb_pkg::HALF_W-1:0] first_ff, first_in;
   logic                         armed_ff, armed_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   dspmb_pkg::rsp_type           rsp_ff, rsp_in;

   dspmb_pkg::sum_type           tail_sum;
   dspmb_pkg::idx_type           tail_idx;
   logic [dspmb_pkg::WORD_W-1:0] seen_next;
   logic [dspmb_pkg::HALF_W-1:0] first_hi;
   logic                         finish;
   logic [dspmb_pkg::WORD_W-1:0] rd_data;

   dspmb_ram #(
      .WIDTH (dspmb_pkg::WORD_W),
      .DEPTH (dspmb_pkg::MAILBOX_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.post),
      .wr_addr (tail_idx),
      .wr_data (word_ff),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == dspmb_pkg::DEPTH_CNT);

   always_comb begin
      // tail = (head + count) mod depth; sum stays below twice the depth
      tail_sum = dspmb_pkg::sum_type'(head_ff) + dspmb_pkg::sum_type'(count_ff);
      if (tail_sum >= dspmb_pkg::DEPTH_SUM) begin
         tail_sum = tail_sum - dspmb_pkg::DEPTH_SUM;
      end
      tail_idx = tail_sum[dspmb_pkg::IDX_W-1:0];

      seen_next = seen_ff + 32'd1;
      first_hi  = (seen_ff == '0) ? word_ff[dspmb_pkg::WORD_W-1:dspmb_pkg::HALF_W] : first_ff;
      finish    = cmd.send && armed_ff && (seen_next == len_ff);

      word_in      = cmd.load ? mail_word : word_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      seen_in      = seen_ff;
      first_in     = first_ff;
      armed_in     = armed_ff;
      rsp_valid_in = cmd.exec;

      if (cmd.post) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.pop) begin
         head_in  = (head_ff == dspmb_pkg::LAST_IDX) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (cmd.send) begin
         last_in = word_ff;
         if (armed_ff) begin
            first_in = first_hi;
            seen_in  = seen_next;
            if (finish) begin
               armed_in = 1'b0;
            end
         end
      end
      if (cmd.arm) begin
         len_in   = (last_ff != '0) ? last_ff : dspmb_pkg::DEFAULT_FRAME_LEN;
         seen_in  = '0;
         armed_in = 1'b1;
      end

      rsp_in = rsp_ff;
      if (cmd.exec) begin
         rsp_in.read_data    = '0;
         rsp_in.finish_valid = finish;
         rsp_in.finish_id    = finish ? first_hi : '0;
         if (cmd.check) begin
            rsp_in.read_data = dspmb_pkg::STATUS_FLAG |
               {{dspmb_pkg::HALF_W{1'b0}}, rd_data[dspmb_pkg::WORD_W-1:dspmb_pkg::HALF_W]};
         end else if (cmd.pop) begin
            rsp_in.read_data = rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         last_ff      <= '0;
         len_ff       <= '0;
         seen_ff      <= '0;
         first_ff     <= '0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         first_ff     <= first_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff <= word_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= dspmb_pkg::DEPTH_CNT, "ring count over depth")
   `ASSERT_NEXT(a_finish_disarms, clock, reset, finish, !armed_ff && rsp_ff.finish_valid, "finish left frame armed")
   `ASSERT_NEXT(a_pop_count, clock, reset, cmd.pop, count_ff == $past(count_ff) - 1'b1, "pop did not drop count")
   `ASSERT_ALWAYS(a_no_post_and_pop, clock, reset, !(cmd.post && cmd.pop), "post and pop together")

endmodule

FILE: design/dsp_mailbox_with_command_framing.sv
// A request is registered when start is seen while idle; its result is computed in the
// execute state and registered onto rsp_valid and rsp_data.
// A new request is taken only while idle; busy is high for the single execute cycle
// that waits on the registered read of the ring memory.
// Reset (synchronous, active high) clears pointers, count, frame state and the strobe;
// ring contents are not cleared. The receiver cannot stall: each result shows for one cycle.
module dsp_mailbox_with_command_framing (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  dspmb_pkg::req_type req_data,
   output logic               rsp_valid,
   output dspmb_pkg::rsp_type rsp_data
);

   dspmb_pkg::cmd_type    cmd;
   dspmb_pkg::status_type status;

   dspmb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_data.action),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   dspmb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .mail_word (req_data.mail_word),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
